// ===== src/uhr_pkg.sv =====
// shared types, constants and helper functions of the udp/ip header rewriter
package uhr_pkg;

  localparam int unsigned ETH_WORDS    = 7;
  localparam int unsigned IP_MIN_WORDS = 10;
  localparam int unsigned HW_W         = 6;
  localparam int unsigned POS_W        = 16;
  localparam int unsigned ACC_W        = 17;
  localparam int unsigned APB_AW       = 6;
  localparam int unsigned APB_DW       = 64;

  // held header word positions
  localparam logic [HW_W-1:0] IDX_DMAC_HI = 6'd0;
  localparam logic [HW_W-1:0] IDX_DMAC_MD = 6'd1;
  localparam logic [HW_W-1:0] IDX_DMAC_LO = 6'd2;
  localparam logic [HW_W-1:0] IDX_CKSUM   = 6'd12;
  localparam logic [HW_W-1:0] IDX_SIP_HI  = 6'd13;
  localparam logic [HW_W-1:0] IDX_SIP_LO  = 6'd14;
  localparam logic [HW_W-1:0] IDX_DIP_HI  = 6'd15;
  localparam logic [HW_W-1:0] IDX_DIP_LO  = 6'd16;

  // udp word offsets behind the ip header
  localparam logic [POS_W-1:0] UDP_SPORT = 16'd0;
  localparam logic [POS_W-1:0] UDP_DPORT = 16'd1;
  localparam logic [POS_W-1:0] UDP_CKSUM = 16'd3;

  localparam logic [1:0] BYTES_ONE = 2'd1;
  localparam logic [1:0] BYTES_TWO = 2'd2;

  localparam logic [2:0] REG_DST_MAC  = 3'd0;
  localparam logic [2:0] REG_SRC_IP   = 3'd1;
  localparam logic [2:0] REG_DST_IP   = 3'd2;
  localparam logic [2:0] REG_SRC_PORT = 3'd3;
  localparam logic [2:0] REG_DST_PORT = 3'd4;

  typedef struct packed {
    logic [15:0] data_word;
    logic [1:0]  byte_count;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_word;
    logic [1:0]  out_bytes;
    logic        out_last;
    logic        truncated;
  } out_item_t;

  typedef struct packed {
    logic [47:0] new_dst_mac;
    logic [31:0] new_src_ip;
    logic [31:0] new_dst_ip;
    logic [15:0] new_src_port;
    logic [15:0] new_dst_port;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_release;
    logic out_free;
    logic run_done;
  } dp_status_t;

  function automatic logic [15:0] rewrite_word(logic [HW_W-1:0] idx, logic [15:0] raw,
                                               cfg_t cfg);
    logic [15:0] v;
    unique case (idx)
      IDX_DMAC_HI: v = cfg.new_dst_mac[47:32];
      IDX_DMAC_MD: v = cfg.new_dst_mac[31:16];
      IDX_DMAC_LO: v = cfg.new_dst_mac[15:0];
      IDX_CKSUM:   v = 16'h0000;
      IDX_SIP_HI:  v = cfg.new_src_ip[31:16];
      IDX_SIP_LO:  v = cfg.new_src_ip[15:0];
      IDX_DIP_HI:  v = cfg.new_dst_ip[31:16];
      IDX_DIP_LO:  v = cfg.new_dst_ip[15:0];
      default:     v = raw;
    endcase
    return v;
  endfunction

  // ones-complement add with end-around carry folded back in
  function automatic logic [ACC_W-1:0] fold_add(logic [ACC_W-1:0] acc, logic [15:0] w);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + {2'b00, w};
    return {1'b0, s[15:0]} + {15'b0, s[ACC_W:16]};
  endfunction

  function automatic logic [15:0] mask_word(logic [15:0] w, logic one_byte);
    return one_byte ? {w[15:8], 8'h00} : w;
  endfunction

endpackage

// ===== src/uhr_regs.sv =====
// apb register file holding the rewrite values
module uhr_regs import uhr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DST_MAC:  cfg_q.new_dst_mac  <= pwdata[47:0];
        REG_SRC_IP:   cfg_q.new_src_ip   <= pwdata[31:0];
        REG_DST_IP:   cfg_q.new_dst_ip   <= pwdata[31:0];
        REG_SRC_PORT: cfg_q.new_src_port <= pwdata[15:0];
        REG_DST_PORT: cfg_q.new_dst_port <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DST_MAC:  prdata = {16'h0000, cfg_q.new_dst_mac};
      REG_SRC_IP:   prdata = {32'h0, cfg_q.new_src_ip};
      REG_DST_IP:   prdata = {32'h0, cfg_q.new_dst_ip};
      REG_SRC_PORT: prdata = {48'h0, cfg_q.new_src_port};
      REG_DST_PORT: prdata = {48'h0, cfg_q.new_dst_port};
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/uhr_datapath.sv =====
// header store, checksum accumulator, position counters and output register
module uhr_datapath import uhr_pkg::*; #(
  parameter int unsigned MAX_HEADER_WORDS = 37
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  in_item_t   in_data_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o
);

  localparam int unsigned AW = $clog2(MAX_HEADER_WORDS);

  logic [15:0] mem [MAX_HEADER_WORDS];
  logic [15:0] rdata_q;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [HW_W-1:0]  hw_q, hw_d;
  logic [ACC_W-1:0] acc_q, acc_d;

  logic [AW-1:0] idx_q, idx_d, end_q, end_d;
  logic          run_trunc_q, run_trunc_d;
  logic          run_last_q, run_last_d;
  logic          run_one_q, run_one_d;
  logic [15:0]   ck_q, ck_d;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic             last_w, one_byte, in_hdr, at_ihl, rel_full, rel_trunc;
  logic [3:0]       ihl, ihl_eff;
  logic [HW_W-1:0]  hw_sum, hw_new, hw_eff;
  logic [POS_W-1:0] udp_off;
  logic [ACC_W-1:0] acc_add;
  logic [15:0]      pass_word, emit_word;
  logic             is_final, emit_one;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  // input word decode
  assign last_w   = in_data_i.last_word;
  assign one_byte = (in_data_i.byte_count == BYTES_ONE) && last_w;
  assign in_hdr   = pos_q < POS_W'(hw_q);
  assign at_ihl   = pos_q == POS_W'(ETH_WORDS);
  assign ihl      = in_data_i.data_word[11:8];
  assign ihl_eff  = (ihl < 4'd5) ? 4'd5 : ihl;
  assign hw_sum   = HW_W'(ETH_WORDS) + {1'b0, ihl_eff, 1'b0};
  assign hw_new   = (hw_sum > HW_W'(MAX_HEADER_WORDS)) ? HW_W'(MAX_HEADER_WORDS) : hw_sum;
  assign hw_eff   = at_ihl ? hw_new : hw_q;
  assign acc_add  = fold_add(acc_q, rewrite_word(pos_q[HW_W-1:0], in_data_i.data_word, cfg_i));
  assign rel_full  = in_hdr && ((pos_q + POS_W'(1)) == POS_W'(hw_eff)) && !one_byte;
  assign rel_trunc = in_hdr && !rel_full && last_w;
  assign udp_off  = pos_q - POS_W'(hw_q);

  always_comb begin
    if (udp_off == UDP_SPORT) begin
      pass_word = cfg_i.new_src_port;
    end else if (udp_off == UDP_DPORT) begin
      pass_word = cfg_i.new_dst_port;
    end else if (udp_off == UDP_CKSUM) begin
      pass_word = 16'h0000;
    end else begin
      pass_word = in_data_i.data_word;
    end
  end

  // word of the held run currently in the read register
  assign is_final = idx_q == end_q;
  assign emit_one = run_trunc_q && is_final && run_one_q;
  always_comb begin
    if (run_trunc_q) begin
      emit_word = rdata_q;
    end else if (idx_q == AW'(IDX_CKSUM)) begin
      emit_word = ck_q;
    end else begin
      emit_word = rewrite_word(HW_W'(idx_q), rdata_q, cfg_i);
    end
  end

  assign rd_en   = cmd_i.fetch || (cmd_i.emit && !is_final);
  assign rd_addr = cmd_i.fetch ? '0 : idx_q + AW'(1);

  always_comb begin
    pos_d       = pos_q;
    hw_d        = hw_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    end_d       = end_q;
    run_trunc_d = run_trunc_q;
    run_last_d  = run_last_q;
    run_one_d   = run_one_q;
    ck_d        = ck_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (cmd_i.accept) begin
      if (in_hdr) begin
        if (at_ihl) begin
          hw_d = hw_new;
        end
        if (pos_q >= POS_W'(ETH_WORDS)) begin
          acc_d = acc_add;
        end
        if (rel_full || rel_trunc) begin
          end_d       = pos_q[AW-1:0];
          run_trunc_d = rel_trunc;
          run_last_d  = last_w;
          run_one_d   = one_byte;
          // checksum must include this word's contribution
          ck_d        = ~((pos_q >= POS_W'(ETH_WORDS)) ? acc_add[15:0] : acc_q[15:0]);
        end
      end else begin
        out_valid_d       = 1'b1;
        out_d.out_word    = mask_word(pass_word, one_byte);
        out_d.out_bytes   = one_byte ? BYTES_ONE : BYTES_TWO;
        out_d.out_last    = last_w;
        out_d.truncated   = 1'b0;
      end
      if (last_w) begin
        pos_d = '0;
        hw_d  = HW_W'(ETH_WORDS + IP_MIN_WORDS);
        acc_d = '0;
      end else if (pos_q != {POS_W{1'b1}}) begin
        pos_d = pos_q + POS_W'(1);
      end
    end

    if (cmd_i.fetch) begin
      idx_d = '0;
    end

    if (cmd_i.emit) begin
      out_valid_d     = 1'b1;
      out_d.out_word  = mask_word(emit_word, emit_one);
      out_d.out_bytes = emit_one ? BYTES_ONE : BYTES_TWO;
      out_d.out_last  = is_final && (run_trunc_q || run_last_q);
      out_d.truncated = run_trunc_q;
      if (!is_final) begin
        idx_d = idx_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hw_q        <= HW_W'(ETH_WORDS + IP_MIN_WORDS);
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      end_q       <= '0;
      run_trunc_q <= 1'b0;
      run_last_q  <= 1'b0;
      run_one_q   <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      hw_q        <= hw_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      run_trunc_q <= run_trunc_d;
      run_last_q  <= run_last_d;
      run_one_q   <= run_one_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ck_q  <= ck_d;
    out_q <= out_d;
  end

  // header store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_hdr) begin
      mem[pos_q[AW-1:0]] <= in_data_i.data_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign status_o.in_release = rel_full || rel_trunc;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.run_done   = is_final;
  assign out_valid_o         = out_valid_q;
  assign out_data_o          = out_q;

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("header word emitted over an untaken output word");

  a_run_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fetch |-> (32'(end_q) < MAX_HEADER_WORDS))
    else $error("release run ends beyond the header store");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.accept && last_w) |=> (pos_q == '0 && acc_q == '0))
    else $error("frame state not restarted after last word");

endmodule

// ===== src/uhr_ctrl.sv =====
// controller sequencing input acceptance and header run release
module uhr_ctrl import uhr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o   = (state_q == S_IDLE) && status_i.out_free;
  assign cmd_o.accept = in_valid_i && in_ready_o;
  assign cmd_o.fetch  = state_q == S_FETCH;
  assign cmd_o.emit   = (state_q == S_DRAIN) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.accept && status_i.in_release) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (cmd_o.emit && status_i.run_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_input_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input word taken during header release");

endmodule

// ===== src/udp_ip_header_rewriter_core.sv =====
// Frame rewriter: one 16-bit big-endian frame word per handshake on each side.
// Input words (in_valid_i/in_ready_o) carry data, byte count and a last flag;
// output words (out_valid_o/out_ready_i) carry the rewritten word, its byte
// count, last and a truncated flag. The apb port holds the new destination
// mac, ip addresses and udp ports; write it only while no frame is in flight.
// Ethernet and ip header words (17 up to MAX_HEADER_WORDS) are absorbed into
// a header store, one per cycle while input is ready, with the ip checksum
// summed as they arrive. On the last header word the held run is released
// from the store through its registered read port: a fetch state, then one
// word per cycle while the output register is free; no input is taken
// during the release. Words after the header pass through the output
// register, udp ports and checksum rewritten on the way. A frame ending
// inside its header is released unmodified with truncated set on every word.
// Reset clears the frame position, the checksum and the registers; the store
// needs no clearing. A stalled receiver holds the output register and input
// is taken only when that register is free or being emptied.
module udp_ip_header_rewriter_core import uhr_pkg::*; #(
  parameter int unsigned MAX_HEADER_WORDS = 37
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  uhr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  uhr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  uhr_datapath #(
    .MAX_HEADER_WORDS (MAX_HEADER_WORDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/rewrite_checker.sv =====
`timescale 1ns / 1ps
// scoreboard of the header rewriter: predicts every output word and compares it
module rewrite_checker import uhr_pkg::*; #(
  parameter int unsigned HDR_CAP = 37
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_o,
  input  in_item_t          in_data_i,
  input  logic              out_valid_o,
  input  logic              out_ready_i,
  input  out_item_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o
);

  localparam int unsigned REPORT_MAX = 10;
  localparam int unsigned POS_MAX    = 16'hFFFF;

  logic [47:0] mac_q;
  logic [31:0] sip_q;
  logic [31:0] dip_q;
  logic [15:0] sport_q;
  logic [15:0] dport_q;

  logic [15:0] hdr_mem [HDR_CAP];
  int unsigned frame_pos;
  int unsigned hdr_len;
  int unsigned ck_acc;
  out_item_t   expected_words [$];

  // held header word with the new addresses patched in
  function automatic logic [15:0] patched_word(int unsigned p, logic [15:0] raw);
    logic [15:0] v;
    v = raw;
    case (p)
      IDX_DMAC_HI: v = mac_q[47:32];
      IDX_DMAC_MD: v = mac_q[31:16];
      IDX_DMAC_LO: v = mac_q[15:0];
      IDX_CKSUM:   v = 16'h0000;
      IDX_SIP_HI:  v = sip_q[31:16];
      IDX_SIP_LO:  v = sip_q[15:0];
      IDX_DIP_HI:  v = dip_q[31:16];
      IDX_DIP_LO:  v = dip_q[15:0];
      default:     v = raw;
    endcase
    return v;
  endfunction

  function automatic void queue_word(logic [15:0] w, logic [1:0] nb, logic fin, logic trunc);
    out_item_t o;
    o.out_word  = (nb == BYTES_ONE) ? {w[15:8], 8'h00} : w;
    o.out_bytes = nb;
    o.out_last  = fin;
    o.truncated = trunc;
    expected_words.push_back(o);
  endfunction

  task automatic predict_rewrite(in_item_t it);
    logic [1:0]  nb;
    logic [15:0] v;
    int unsigned p;
    int unsigned ihl;
    int unsigned span;
    int unsigned u;
    int unsigned i;
    p  = frame_pos;
    nb = (it.byte_count == BYTES_ONE && it.last_word) ? BYTES_ONE : BYTES_TWO;
    if (p < hdr_len) begin
      if (p < HDR_CAP) hdr_mem[p] = it.data_word;
      if (p == ETH_WORDS) begin
        ihl = it.data_word[11:8];
        if (ihl < 5) ihl = 5;
        span    = ETH_WORDS + 2 * ihl;
        hdr_len = (span > HDR_CAP) ? HDR_CAP : span;
      end
      if (p >= ETH_WORDS) begin
        ck_acc = ck_acc + patched_word(p, it.data_word);
        ck_acc = (ck_acc & 16'hFFFF) + (ck_acc >> 16);
      end
      if (p + 1 == hdr_len && nb == BYTES_TWO) begin
        for (i = 0; i <= p && i < HDR_CAP; i++) begin
          v = (i == IDX_CKSUM) ? ~ck_acc[15:0] : patched_word(i, hdr_mem[i]);
          queue_word(v, BYTES_TWO, it.last_word && i == p, 1'b0);
        end
      end else if (it.last_word) begin
        // header cut short: held words go out untouched
        for (i = 0; i <= p && i < HDR_CAP; i++)
          queue_word(hdr_mem[i], (i == p) ? nb : BYTES_TWO, i == p, 1'b1);
      end
    end else begin
      u = p - hdr_len;
      v = it.data_word;
      if (u == UDP_SPORT) v = sport_q;
      else if (u == UDP_DPORT) v = dport_q;
      else if (u == UDP_CKSUM) v = 16'h0000;
      queue_word(v, nb, it.last_word, 1'b0);
    end
    if (it.last_word) begin
      frame_pos = 0;
      hdr_len   = ETH_WORDS + IP_MIN_WORDS;
      ck_acc    = 0;
    end else if (frame_pos < POS_MAX) begin
      frame_pos++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      mac_q        = '0;
      sip_q        = '0;
      dip_q        = '0;
      sport_q      = '0;
      dport_q      = '0;
      frame_pos    = 0;
      hdr_len      = ETH_WORDS + IP_MIN_WORDS;
      ck_acc       = 0;
      fail_count_o = 0;
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          REG_DST_MAC:  mac_q   = pwdata[47:0];
          REG_SRC_IP:   sip_q   = pwdata[31:0];
          REG_DST_IP:   dip_q   = pwdata[31:0];
          REG_SRC_PORT: sport_q = pwdata[15:0];
          REG_DST_PORT: dport_q = pwdata[15:0];
          default: ;
        endcase
      end
      // compare before predicting, a word never leaves in the cycle it arrives
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_MAX)
            $display("%0t: unexpected output word %h bytes %0d last %b trunc %b", $realtime,
                     out_data_o.out_word, out_data_o.out_bytes, out_data_o.out_last,
                     out_data_o.truncated);
        end else begin
          want = expected_words.pop_front();
          if (out_data_o.out_word !== want.out_word || out_data_o.out_bytes !== want.out_bytes ||
              out_data_o.out_last !== want.out_last || out_data_o.truncated !== want.truncated)
              begin
            fail_count_o++;
            if (fail_count_o <= REPORT_MAX)
              $display("%0t: word mismatch, expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                       $realtime, want.out_word, want.out_bytes, want.out_last,
                       want.truncated, out_data_o.out_word, out_data_o.out_bytes,
                       out_data_o.out_last, out_data_o.truncated);
          end
        end
      end
      if (in_valid_i && in_ready_o) predict_rewrite(in_data_i);
    end
    pending_o = expected_words.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// top level of the header rewriter testbench: frame stimulus, register set-up and verdict
module testbench import uhr_pkg::*;;

  localparam int unsigned CLK_PERIOD    = 4;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_LIMIT   = 20_000;
  localparam int unsigned SETTLE_CYCLES = 45;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PRESSURE_AT   = 40;
  localparam int unsigned PHASE_WORDS   = 8;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  in_item_t          in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_item_t         out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned fails;
  int unsigned pending;
  int unsigned words_sent  = 0;
  int unsigned tx_calm     = 0;
  int unsigned cycle_count = 0;
  logic        hold_rx     = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  udp_ip_header_rewriter_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  rewrite_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // leaves valid high after the word is taken, the next call lowers it if a gap follows
  task automatic send_word(in_item_t it);
    int unsigned gap;
    gap = 0;
    if (tx_calm > 0) tx_calm--;
    else if ($urandom_range(0, 99) < 25) gap = idle_span();
    else if ($urandom_range(0, 99) < 5) tx_calm = $urandom_range(20, 80);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  // ihl or last_bc below zero leaves that field random
  task automatic send_frame(int ihl, int unsigned n_words, int last_bc, fill_e fill);
    in_item_t    it;
    int unsigned k;
    for (k = 0; k < n_words; k++) begin
      case (fill)
        FILL_ZERO: it.data_word = '0;
        FILL_ONES: it.data_word = '1;
        default:   it.data_word = 16'($urandom);
      endcase
      if (k == ETH_WORDS && ihl >= 0) it.data_word[11:8] = 4'(ihl);
      it.last_word = (k == n_words - 1);
      if (it.last_word && last_bc >= 0) it.byte_count = 2'(last_bc);
      else if (it.last_word || $urandom_range(0, 99) < 15) it.byte_count = 2'($urandom_range(0, 3));
      else it.byte_count = BYTES_TWO;
      send_word(it);
    end
  endtask

  task automatic random_frame();
    int unsigned r;
    int unsigned ihl;
    int unsigned hw;
    r   = $urandom_range(0, 99);
    ihl = ($urandom_range(0, 1) == 0) ? 5 : $urandom_range(0, 15);
    hw  = ETH_WORDS + 2 * ((ihl < 5) ? 5 : ihl);
    if (r < 65) send_frame(ihl, hw + $urandom_range(0, 10), -1, FILL_RANDOM);
    else if (r < 90) send_frame(ihl, $urandom_range(1, hw), -1, FILL_RANDOM);
    else send_frame(-1, $urandom_range(1, 4), -1, FILL_RANDOM);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // psel stays high between back-to-back writes
  task automatic apb_write(logic [2:0] idx, logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic program_rewrite(logic [47:0] mac, logic [31:0] sip, logic [31:0] dip,
                                 logic [15:0] sport, logic [15:0] dport);
    settle();
    apb_write(REG_DST_MAC, APB_DW'(mac));
    apb_write(REG_SRC_IP, APB_DW'(sip));
    apb_write(REG_DST_IP, APB_DW'(dip));
    apb_write(REG_SRC_PORT, APB_DW'(sport));
    apb_write(REG_DST_PORT, APB_DW'(dport));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin : rx_side
    int unsigned gap;
    int unsigned calm;
    gap         = 0;
    calm        = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_rx || gap > 0) begin
        out_ready_i <= 1'b0;
        if (!hold_rx) gap--;
      end else begin
        out_ready_i <= 1'b1;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 99) < 20) gap = idle_span();
        else if ($urandom_range(0, 99) < 5) calm = $urandom_range(20, 80);
      end
    end
  end

  // long receiver stall while words keep coming, so the block backs up
  initial begin : rx_hold
    wait (words_sent >= PRESSURE_AT);
    @(posedge clk_i);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned start;
    int unsigned k;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    program_rewrite(48'({$urandom, $urandom}), $urandom, $urandom, 16'($urandom),
                    16'($urandom));
    send_frame(5, 24, 1, FILL_RANDOM);   // plain frame, odd final byte
    send_frame(0, 17, 2, FILL_ZERO);     // ihl below five, frame ends with the header
    send_frame(15, 39, 3, FILL_ONES);    // widest header, udp header cut short
    send_frame(5, 11, 2, FILL_RANDOM);   // ends inside the ip header
    send_frame(5, 17, 1, FILL_RANDOM);   // last header word holds one byte only
    send_frame(5, 1, 1, FILL_ONES);      // single odd byte
    send_frame(7, 27, 0, FILL_RANDOM);   // ip options, zero byte count on last word

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: program_rewrite('1, '1, '1, '1, '1);
        1: program_rewrite('0, '0, '0, '0, '0);
        default: program_rewrite(48'({$urandom, $urandom}), $urandom, $urandom,
                                 16'($urandom), 16'($urandom));
      endcase
      start = words_sent;
      while (words_sent - start < PHASE_WORDS) random_frame();
    end

    in_valid_i <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && pending != 0; k++) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== udp_ip_header_rewriter_core.f =====
src/uhr_pkg.sv
src/uhr_regs.sv
src/uhr_datapath.sv
src/uhr_ctrl.sv
src/udp_ip_header_rewriter_core.sv
tb/rewrite_checker.sv
tb/testbench.sv
